>>> sv/fsmr_pkg.sv
// shared types and codes for the flagged slot message ring
package fsmr_pkg;

  localparam int WORD_W    = 64;
  localparam int MSG_WORDS = 7;
  localparam int MSG_W     = WORD_W * MSG_WORDS;
  localparam int RING_W    = 7;
  localparam int BLK_W     = 7;

  localparam logic [RING_W-1:0] RING_LINES_RST = 7'd64;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NO_MSG = 2'd1;
  localparam logic [1:0] STAT_RETRY  = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [BLK_W-1:0] need_slots;
    logic             wait_flag;
    logic [63:0]      in_word_0;
    logic [63:0]      in_word_1;
    logic [63:0]      in_word_2;
    logic [63:0]      in_word_3;
    logic [63:0]      in_word_4;
    logic [63:0]      in_word_5;
    logic [63:0]      in_word_6;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        read_ready;
    logic        space_ok;
    logic [63:0] out_word_0;
    logic [63:0] out_word_1;
    logic [63:0] out_word_2;
    logic [63:0] out_word_3;
    logic [63:0] out_word_4;
    logic [63:0] out_word_5;
    logic [63:0] out_word_6;
  } out_word_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       read_ready;
    logic       space_ok;
    logic       rd_ok;
  } ctrl_res_t;

endpackage

>>> sv/fsmr_msg_mem.sv
// message row memory, one row per slot, registered read
module fsmr_msg_mem import fsmr_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [MSG_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [MSG_W-1:0] rdata_o
);

  logic [MSG_W-1:0] mem [DEPTH];
  logic [MSG_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/fsmr_ctrl.sv
// slot flags, ring positions, space scan and result control
module fsmr_ctrl import fsmr_pkg::*; #(
  parameter int MAX_SLOTS = 64,
  parameter int PW        = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we_i,
  input  logic [RING_W-1:0] cfg_wdata_i,
  input  logic [1:0]        command_i,
  input  logic [BLK_W-1:0]  need_slots_i,
  input  logic              wait_flag_i,
  output logic              mem_we_o,
  output logic [PW-1:0]     mem_waddr_o,
  output logic              mem_re_o,
  output logic [PW-1:0]     mem_raddr_o,
  output ctrl_res_t         res_o
);

  localparam int CW = (PW + 1 > RING_W) ? PW + 1 : RING_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state_q, state_d;
  logic [RING_W-1:0]    ring_lines_q;
  logic [MAX_SLOTS-1:0] flags_q, flags_d;
  logic [PW-1:0]        wp_q, wp_d, rp_q, rp_d;
  logic [PW-1:0]        scan_pos_q, scan_pos_d;
  logic [BLK_W-1:0]     scan_cnt_q, scan_cnt_d;
  logic                 valid_q, valid_d;
  logic [1:0]           status_q, status_d;
  logic                 space_ok_q, space_ok_d;
  logic                 rd_ok_q, rd_ok_d;
  logic [CW-1:0]        lines;
  logic                 accept;

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] pos,
                                             input logic [CW-1:0] n);
    logic [CW-1:0] inc;
    inc = CW'(pos) + CW'(1);
    return (inc >= n) ? '0 : inc[PW-1:0];
  endfunction

  always_comb begin
    lines = CW'(ring_lines_q);
    if (lines < CW'(2)) begin
      lines = CW'(2);
    end else if (lines > CW'(MAX_SLOTS)) begin
      lines = CW'(MAX_SLOTS);
    end
  end

  assign busy   = (state_q == ST_SCAN);
  assign accept = start && !busy;

  always_comb begin
    state_d    = state_q;
    flags_d    = flags_q;
    wp_d       = wp_q;
    rp_d       = rp_q;
    scan_pos_d = scan_pos_q;
    scan_cnt_d = scan_cnt_q;
    valid_d    = 1'b0;
    status_d   = status_q;
    space_ok_d = space_ok_q;
    rd_ok_d    = rd_ok_q;
    mem_we_o   = 1'b0;
    mem_re_o   = 1'b0;
    if (accept) begin
      status_d   = STAT_OK;
      space_ok_d = 1'b0;
      rd_ok_d    = 1'b0;
      valid_d    = 1'b1;
      case (command_i)
        CMD_WRITE: begin
          if (!flags_q[wp_q]) begin
            mem_we_o        = 1'b1;
            flags_d[wp_q]   = 1'b1;
            wp_d            = next_pos(wp_q, lines);
          end else begin
            status_d = STAT_RETRY;
          end
        end
        CMD_READ: begin
          if (flags_q[rp_q]) begin
            mem_re_o      = 1'b1;
            rd_ok_d       = 1'b1;
            flags_d[rp_q] = 1'b0;
            rp_d          = next_pos(rp_q, lines);
          end else begin
            status_d = wait_flag_i ? STAT_RETRY : STAT_NO_MSG;
          end
        end
        CMD_CHECK: begin
          if (need_slots_i == '0) begin
            space_ok_d = 1'b1;
          end else begin
            valid_d    = 1'b0;
            state_d    = ST_SCAN;
            scan_pos_d = wp_q;
            scan_cnt_d = need_slots_i;
          end
        end
        default: begin
        end
      endcase
    end else if (busy) begin
      if (flags_q[scan_pos_q]) begin
        valid_d    = 1'b1;
        space_ok_d = 1'b0;
        state_d    = ST_IDLE;
      end else if (scan_cnt_q == BLK_W'(1)) begin
        valid_d    = 1'b1;
        space_ok_d = 1'b1;
        state_d    = ST_IDLE;
      end else begin
        scan_cnt_d = scan_cnt_q - BLK_W'(1);
        scan_pos_d = next_pos(scan_pos_q, lines);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ring_lines_q <= RING_LINES_RST;
      flags_q      <= '0;
      wp_q         <= PW'(1);
      rp_q         <= PW'(1);
      valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      flags_q <= flags_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        ring_lines_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_pos_q <= scan_pos_d;
    scan_cnt_q <= scan_cnt_d;
    status_q   <= status_d;
    space_ok_q <= space_ok_d;
    rd_ok_q    <= rd_ok_d;
  end

  assign mem_waddr_o = wp_q;
  assign mem_raddr_o = rp_q;

  // positions and flags already hold the post-step state in the strobe cycle
  assign res_o.valid      = valid_q;
  assign res_o.status     = status_q;
  assign res_o.read_ready = flags_q[rp_q];
  assign res_o.space_ok   = space_ok_q;
  assign res_o.rd_ok      = rd_ok_q;

endmodule

>>> sv/flagged_slot_message_ring.sv
// latency: write, read and other commands strobe a result in the cycle after start
// latency: a space check strobes j + 1 cycles after start, j = slots scanned (0 to need_slots)
// throughput: one write or read per cycle; busy is high only while the flag scan runs
// the receiver cannot stall; each result is shown for exactly one cycle
// reset clears all slot flags, sets both positions to slot 1 and ring_lines to 64
// message rows are not cleared; a row is only read after it has been written
module flagged_slot_message_ring import fsmr_pkg::*; #(
  parameter int MAX_SLOTS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we_i,
  input  logic [RING_W-1:0] cfg_wdata_i,
  input  in_word_t          word_i,
  output logic              result_valid_o,
  output out_word_t         result_o
);

  localparam int PW = $clog2(MAX_SLOTS);

  logic             mem_we, mem_re;
  logic [PW-1:0]    mem_waddr, mem_raddr;
  logic [MSG_W-1:0] mem_wdata, mem_rdata, rd_words;
  ctrl_res_t        res;

  assign mem_wdata = {word_i.in_word_6, word_i.in_word_5, word_i.in_word_4,
                      word_i.in_word_3, word_i.in_word_2, word_i.in_word_1,
                      word_i.in_word_0};

  fsmr_ctrl #(
    .MAX_SLOTS(MAX_SLOTS),
    .PW       (PW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .command_i    (word_i.command),
    .need_slots_i (word_i.need_slots),
    .wait_flag_i  (word_i.wait_flag),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .res_o        (res)
  );

  fsmr_msg_mem #(
    .DEPTH(MAX_SLOTS),
    .AW   (PW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rd_words = res.rd_ok ? mem_rdata : '0;

  assign result_valid_o      = res.valid;
  assign result_o.status     = res.status;
  assign result_o.read_ready = res.read_ready;
  assign result_o.space_ok   = res.space_ok;
  assign result_o.out_word_0 = rd_words[0*WORD_W +: WORD_W];
  assign result_o.out_word_1 = rd_words[1*WORD_W +: WORD_W];
  assign result_o.out_word_2 = rd_words[2*WORD_W +: WORD_W];
  assign result_o.out_word_3 = rd_words[3*WORD_W +: WORD_W];
  assign result_o.out_word_4 = rd_words[4*WORD_W +: WORD_W];
  assign result_o.out_word_5 = rd_words[5*WORD_W +: WORD_W];
  assign result_o.out_word_6 = rd_words[6*WORD_W +: WORD_W];

endmodule

>>> sv/fsmr_checker.sv
// port-level checks for the flagged slot message ring and their binding
module fsmr_checker import fsmr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_word_t  word_i,
  input logic      result_valid_o,
  input out_word_t result_o
);

  // a result only follows an accepted word or a running scan
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a cause");

  // non-check commands answer in the next cycle
  a_fast_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && word_i.command != CMD_CHECK) |=> result_valid_o)
    else $error("missing result one cycle after start");

  // a refused or empty request carries no message
  a_zero_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != STAT_OK) |->
      (result_o.out_word_0 == '0 && result_o.out_word_6 == '0 && !result_o.space_ok))
    else $error("data or space flag on failed request");

  // space_ok only answers a space check
  a_space_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.space_ok) |->
      ($past(busy) || $past(word_i.command) == CMD_CHECK))
    else $error("space_ok on a command other than a space check");

endmodule

bind flagged_slot_message_ring fsmr_checker u_fsmr_checker (.*);
